[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RC frame decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLKED(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg) \
    `ASSERT_CLKED(label, clk_sig, rst_sig, !(cond), msg)

`endif

[hw/rtl/rcsfd_pkg.sv]
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Types and constants of the RC receiver serial frame decoder.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

    localparam int NUM_CHANS    = 6;
    localparam int CHAN_W       = 10;
    localparam int CHAN_IDX_W   = 3;
    localparam int STORE_DEPTH  = 13;
    localparam int STORE_IDX_W  = 4;
    localparam int MARKER_INDEX = 12;
    localparam int LIMIT_W      = 16;
    localparam int COUNT_OUT_W  = 16;

    localparam logic [7:0] SYNC_FIRST  = 8'h03;
    localparam logic [7:0] SYNC_SECOND = 8'h01;
    localparam logic [7:0] MARKER_BYTE = 8'h18;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic REG_TIMEOUT_LIMIT  = 1'b0;
    localparam logic REG_AUTO_THRESHOLD = 1'b1;

    localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RESET  = 16'd100;
    localparam logic [CHAN_W-1:0]  AUTO_THRESHOLD_RESET = 10'd288;

    localparam logic [CHAN_IDX_W-1:0] GAIN_CHAN = 3'd4;

    typedef struct packed {
        logic [LIMIT_W-1:0] timeout_limit;
        logic [CHAN_W-1:0]  auto_threshold;
    } cfg_t;

    typedef struct packed {
        logic [NUM_CHANS-1:0][CHAN_W-1:0] chan;
        logic                             auto_mode;
        logic                             frame_complete;
        logic                             timed_out;
        logic [COUNT_OUT_W-1:0]           tick_count;
    } result_t;

    function automatic logic [CHAN_IDX_W-1:0] slot_id(input int slot);
        logic [CHAN_IDX_W-1:0] id;
        unique case (slot)
            0:       id = 3'd1;
            1:       id = 3'd5;
            2:       id = 3'd2;
            3:       id = 3'd3;
            4:       id = 3'd0;
            5:       id = 3'd4;
            default: id = 3'd0;
        endcase
        return id;
    endfunction

endpackage

[hw/rtl/rcsfd_apb_regs.sv]
// ----------------------------------------------------------------------------
// rcsfd_apb_regs
// APB register bank holding the timeout limit and the auto mode threshold.
// ----------------------------------------------------------------------------
module rcsfd_apb_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output rcsfd_pkg::cfg_t    cfg
);

    rcsfd_pkg::cfg_t cfg_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit  <= rcsfd_pkg::TIMEOUT_LIMIT_RESET;
            cfg_reg.auto_threshold <= rcsfd_pkg::AUTO_THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                rcsfd_pkg::REG_TIMEOUT_LIMIT:
                    cfg_reg.timeout_limit <= pwdata[rcsfd_pkg::LIMIT_W-1:0];
                rcsfd_pkg::REG_AUTO_THRESHOLD:
                    cfg_reg.auto_threshold <= pwdata[rcsfd_pkg::CHAN_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rcsfd_pkg::REG_TIMEOUT_LIMIT:
                prdata = {{(32 - rcsfd_pkg::LIMIT_W){1'b0}}, cfg_reg.timeout_limit};
            rcsfd_pkg::REG_AUTO_THRESHOLD:
                prdata = {{(32 - rcsfd_pkg::CHAN_W){1'b0}}, cfg_reg.auto_threshold};
            default:
                prdata = '0;
        endcase
    end

endmodule

[hw/rtl/rcsfd_frame_core.sv]
// ----------------------------------------------------------------------------
// rcsfd_frame_core
// Frame state, byte store, slot decode, tick count; one event a cycle on step.
// ----------------------------------------------------------------------------
module rcsfd_frame_core #(
    parameter int FRAME_BYTES = 14,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                kind,
    input  logic [7:0]          rx_byte,
    input  rcsfd_pkg::cfg_t     cfg,
    output rcsfd_pkg::result_t  result_next
);

    localparam int POS_BITS = $clog2(FRAME_BYTES + 1);
    localparam int CMP_BITS = (COUNT_BITS > rcsfd_pkg::LIMIT_W) ?
                              COUNT_BITS : rcsfd_pkg::LIMIT_W;

    logic [7:0]                                         last_byte_reg;
    logic [7:0]                                         last_byte_next;
    logic [POS_BITS-1:0]                                pos_reg;
    logic [POS_BITS-1:0]                                pos_next;
    logic [POS_BITS-1:0]                                pos_inc;
    logic [7:0]                                         store_reg [rcsfd_pkg::STORE_DEPTH];
    logic [rcsfd_pkg::NUM_CHANS-1:0][rcsfd_pkg::CHAN_W-1:0] chan_reg;
    logic [rcsfd_pkg::NUM_CHANS-1:0][rcsfd_pkg::CHAN_W-1:0] chan_next;
    logic                                               auto_reg;
    logic                                               auto_next;
    logic                                               complete_reg;
    logic                                               complete_next;
    logic [COUNT_BITS-1:0]                              count_reg;
    logic [COUNT_BITS-1:0]                              count_next;
    logic [CMP_BITS-1:0]                                count_ext;
    logic [CMP_BITS-1:0]                                count_next_ext;
    logic [CMP_BITS-1:0]                                limit_ext;

    logic                                               is_tick;
    logic                                               is_sync;
    logic                                               store_ok;
    logic                                               frame_end;
    logic                                               decode;
    logic                                               write_store;
    logic                                               timed_out;
    logic [rcsfd_pkg::NUM_CHANS-1:0]                    slot_hit;
    logic [rcsfd_pkg::NUM_CHANS-1:0][rcsfd_pkg::CHAN_W-1:0] slot_val;

    assign is_tick  = (kind == rcsfd_pkg::KIND_TICK);
    assign is_sync  = (rx_byte == rcsfd_pkg::SYNC_SECOND) &&
                      (last_byte_reg == rcsfd_pkg::SYNC_FIRST);
    assign store_ok = (pos_reg < POS_BITS'(FRAME_BYTES));
    assign pos_inc  = pos_reg + 1'b1;

    assign frame_end   = !is_tick && !is_sync && store_ok &&
                         (pos_inc == POS_BITS'(FRAME_BYTES));
    assign decode      = frame_end &&
                         (store_reg[rcsfd_pkg::MARKER_INDEX] == rcsfd_pkg::MARKER_BYTE);
    assign write_store = !is_tick && !is_sync && store_ok &&
                         (pos_reg < POS_BITS'(rcsfd_pkg::STORE_DEPTH));

    assign count_ext = CMP_BITS'(count_reg);
    assign limit_ext = CMP_BITS'(cfg.timeout_limit);
    assign timed_out = is_tick && (count_ext > limit_ext);

    always_comb
    begin
        for (int i = 0; i < rcsfd_pkg::NUM_CHANS; i++)
        begin
            slot_hit[i] = (store_reg[2*i][7:2] ==
                           {{(6 - rcsfd_pkg::CHAN_IDX_W){1'b0}}, rcsfd_pkg::slot_id(i)});
            slot_val[i] = {store_reg[2*i][1:0], store_reg[2*i+1]};
        end
    end

    always_comb
    begin
        chan_next = chan_reg;
        auto_next = auto_reg;
        if (decode)
        begin
            for (int i = 0; i < rcsfd_pkg::NUM_CHANS; i++)
            begin
                if (slot_hit[i])
                begin
                    chan_next[rcsfd_pkg::slot_id(i)] = slot_val[i];
                    if (rcsfd_pkg::slot_id(i) == rcsfd_pkg::GAIN_CHAN)
                    begin
                        auto_next = (slot_val[i] <= cfg.auto_threshold);
                    end
                end
            end
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        complete_next  = complete_reg;
        last_byte_next = last_byte_reg;
        count_next     = count_reg;
        if (is_tick)
        begin
            if (!(&count_reg))
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            last_byte_next = rx_byte;
            if (is_sync)
            begin
                pos_next      = '0;
                complete_next = 1'b0;
            end
            else if (store_ok)
            begin
                pos_next = pos_inc;
                if (frame_end)
                begin
                    complete_next = 1'b1;
                end
            end
            if (decode)
            begin
                count_next = '0;
            end
        end
    end

    assign count_next_ext = CMP_BITS'(count_next);

    always_comb
    begin
        result_next.chan           = chan_next;
        result_next.auto_mode      = auto_next;
        result_next.frame_complete = complete_next;
        result_next.timed_out      = timed_out;
        result_next.tick_count     = count_next_ext[rcsfd_pkg::COUNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_byte_reg <= '0;
            pos_reg       <= '0;
            chan_reg      <= '0;
            auto_reg      <= 1'b0;
            complete_reg  <= 1'b0;
            count_reg     <= '0;
        end
        else if (step)
        begin
            last_byte_reg <= last_byte_next;
            pos_reg       <= pos_next;
            chan_reg      <= chan_next;
            auto_reg      <= auto_next;
            complete_reg  <= complete_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && write_store)
        begin
            store_reg[pos_reg[rcsfd_pkg::STORE_IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

[hw/rtl/rc_receiver_serial_frame_decoder.sv]
// ----------------------------------------------------------------------------
// rc_receiver_serial_frame_decoder
// Decodes serial RC receiver frames from received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
// Pipeline: a word enters the input register at its accepting edge and its
// result enters the result register once the output is not stalled.
// Throughput: one word per cycle while the output is not stalled.
// Reset: asynchronous, active low; it clears the frame state and the latched
// channels and loads the register defaults.
module rc_receiver_serial_frame_decoder #(
    parameter int FRAME_BYTES = 14,
    parameter int COUNT_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  chan0,
    output logic [9:0]  chan1,
    output logic [9:0]  chan2,
    output logic [9:0]  chan3,
    output logic [9:0]  chan4,
    output logic [9:0]  chan5,
    output logic        auto_mode,
    output logic        frame_complete,
    output logic        timed_out,
    output logic [15:0] tick_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    rcsfd_pkg::cfg_t    cfg;
    rcsfd_pkg::result_t result_next;
    rcsfd_pkg::result_t res_reg;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_kind_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_accept;
    logic       advance;

    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign advance   = s1_valid_reg && !(out_valid_reg && out_stall);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg <= kind;
            s1_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            res_reg <= result_next;
        end
    end

    rcsfd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcsfd_frame_core #(
        .FRAME_BYTES (FRAME_BYTES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .kind        (s1_kind_reg),
        .rx_byte     (s1_byte_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    assign out_valid      = out_valid_reg;
    assign chan0          = res_reg.chan[0];
    assign chan1          = res_reg.chan[1];
    assign chan2          = res_reg.chan[2];
    assign chan3          = res_reg.chan[3];
    assign chan4          = res_reg.chan[4];
    assign chan5          = res_reg.chan[5];
    assign auto_mode      = res_reg.auto_mode;
    assign frame_complete = res_reg.frame_complete;
    assign timed_out      = res_reg.timed_out;
    assign tick_count     = res_reg.tick_count;

    `ASSERT_CLKED(a_accept_fills, clk, rst_n, in_accept |=> s1_valid_reg, "word lost")
    `ASSERT_CLKED(a_out_source, clk, rst_n, $rose(out_valid) |-> $past(s1_valid_reg), "no source")
    `ASSERT_NEVER(a_no_idle_stall, clk, rst_n, in_stall && !out_stall, "needless stall")

endmodule

[verif/rcsfd_tb_pkg.sv]
// ----------------------------------------------------------------------------
// rcsfd_tb_pkg
// Scoreboard of the RC receiver frame decoder testbench. It keeps its own
// copy of the decoder state, predicts the output of every accepted word and
// compares each output word of the block with the oldest prediction.
// ----------------------------------------------------------------------------
package rcsfd_tb_pkg;

    import rcsfd_pkg::*;

    localparam int FRAME_LEN = 14;

    localparam logic [CHAN_IDX_W-1:0] SLOT_CHAN [NUM_CHANS] =
        '{3'd1, 3'd5, 3'd2, 3'd3, 3'd0, 3'd4};

    class frame_decoder_scoreboard;

        logic [LIMIT_W-1:0]     timeout_limit;
        logic [CHAN_W-1:0]      auto_threshold;
        logic [7:0]             last_byte;
        int unsigned            byte_pos;
        logic [7:0]             frame_bytes [STORE_DEPTH];
        logic [CHAN_W-1:0]      chan_value [NUM_CHANS];
        logic                   auto_flag;
        logic                   complete_flag;
        logic [COUNT_OUT_W-1:0] tick_counter;

        result_t     pending_outputs [$];
        int unsigned mismatches;
        int unsigned outputs_checked;
        int unsigned frames_decoded;
        int unsigned timeouts_seen;

        function new();
            timeout_limit  = TIMEOUT_LIMIT_RESET;
            auto_threshold = AUTO_THRESHOLD_RESET;
            last_byte      = '0;
            byte_pos       = 0;
            auto_flag      = 1'b0;
            complete_flag  = 1'b0;
            tick_counter   = '0;
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
            foreach (chan_value[i]) chan_value[i] = '0;
            mismatches       = 0;
            outputs_checked  = 0;
            frames_decoded   = 0;
            timeouts_seen    = 0;
        endfunction

        function void decode_frame();
            logic [7:0]        hi;
            logic [7:0]        lo;
            logic [CHAN_W-1:0] value;
            if (frame_bytes[MARKER_INDEX] != MARKER_BYTE)
                return;
            frames_decoded++;
            for (int s = 0; s < NUM_CHANS; s++)
            begin
                hi = frame_bytes[2*s];
                lo = frame_bytes[2*s+1];
                if (hi[7:2] == SLOT_CHAN[s])
                begin
                    value = {hi[1:0], lo};
                    chan_value[SLOT_CHAN[s]] = value;
                    if (SLOT_CHAN[s] == GAIN_CHAN)
                        auto_flag = (value <= auto_threshold);
                end
            end
            tick_counter = '0;
        endfunction

        function void note_word(logic word_kind, logic [7:0] data);
            result_t r;
            r = '0;
            if (word_kind == KIND_TICK)
            begin
                r.timed_out = (tick_counter > timeout_limit);
                if (r.timed_out)
                    timeouts_seen++;
                if (tick_counter != '1)
                    tick_counter++;
            end
            else
            begin
                if (data == SYNC_SECOND && last_byte == SYNC_FIRST)
                begin
                    byte_pos      = 0;
                    complete_flag = 1'b0;
                end
                else if (byte_pos < FRAME_LEN)
                begin
                    if (byte_pos < STORE_DEPTH)
                        frame_bytes[byte_pos] = data;
                    byte_pos++;
                    if (byte_pos == FRAME_LEN)
                    begin
                        decode_frame();
                        complete_flag = 1'b1;
                    end
                end
                last_byte = data;
            end
            for (int j = 0; j < NUM_CHANS; j++)
                r.chan[j] = chan_value[j];
            r.auto_mode      = auto_flag;
            r.frame_complete = complete_flag;
            r.tick_count     = tick_counter;
            pending_outputs.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(result_t got);
            result_t exp;
            outputs_checked++;
            if (pending_outputs.size() == 0)
            begin
                report_mismatch("output word with no prediction waiting");
                return;
            end
            exp = pending_outputs.pop_front();
            for (int j = 0; j < NUM_CHANS; j++)
                if (got.chan[j] !== exp.chan[j])
                    report_mismatch($sformatf("output %0d chan%0d got %0d expected %0d",
                        outputs_checked, j, got.chan[j], exp.chan[j]));
            if (got.auto_mode !== exp.auto_mode)
                report_mismatch($sformatf("output %0d auto_mode got %b expected %b",
                    outputs_checked, got.auto_mode, exp.auto_mode));
            if (got.frame_complete !== exp.frame_complete)
                report_mismatch($sformatf("output %0d frame_complete got %b expected %b",
                    outputs_checked, got.frame_complete, exp.frame_complete));
            if (got.timed_out !== exp.timed_out)
                report_mismatch($sformatf("output %0d timed_out got %b expected %b",
                    outputs_checked, got.timed_out, exp.timed_out));
            if (got.tick_count !== exp.tick_count)
                report_mismatch($sformatf("output %0d tick_count got %0d expected %0d",
                    outputs_checked, got.tick_count, exp.tick_count));
        endtask

    endclass

endpackage

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes and millisecond ticks into the RC receiver frame
// decoder with random gaps and output stalls, programs the timeout limit and
// the auto threshold over APB between phases, and checks every output word
// against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rcsfd_pkg::*;
    import rcsfd_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 50000;
    localparam int unsigned PHASE_WORDS   = 198;

    localparam logic [8:0] DIRECTED [22] = '{
        {KIND_TICK, 8'hFF}, {KIND_BYTE, SYNC_FIRST}, {KIND_BYTE, SYNC_SECOND},
        {KIND_BYTE, 8'h07}, {KIND_BYTE, 8'hFF}, {KIND_BYTE, 8'h14}, {KIND_BYTE, 8'h00},
        {KIND_BYTE, 8'h0A}, {KIND_BYTE, 8'h55}, {KIND_BYTE, 8'h0D}, {KIND_BYTE, 8'hAA},
        {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'h11}, {KIND_BYTE, 8'h20},
        {KIND_BYTE, MARKER_BYTE}, {KIND_BYTE, 8'hFF},
        {KIND_BYTE, 8'h00}, {KIND_BYTE, SYNC_FIRST}, {KIND_BYTE, SYNC_SECOND},
        {KIND_TICK, 8'h00}, {KIND_TICK, 8'h5A}
    };

    localparam int unsigned PHASE_LIMIT [6] = '{100, 0, 65535, 3, 40, 0};
    localparam int unsigned PHASE_THRESH [6] = '{288, 1023, 0, 288, 700, 512};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [9:0]  chan0, chan1, chan2, chan3, chan4, chan5;
    logic        auto_mode;
    logic        frame_complete;
    logic        timed_out;
    logic [15:0] tick_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;
    result_t     observed;

    frame_decoder_scoreboard scoreboard = new();

    rc_receiver_serial_frame_decoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chan0          (chan0),
        .chan1          (chan1),
        .chan2          (chan2),
        .chan3          (chan3),
        .chan4          (chan4),
        .chan5          (chan5),
        .auto_mode      (auto_mode),
        .frame_complete (frame_complete),
        .timed_out      (timed_out),
        .tick_count     (tick_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall = ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed.chan           = {chan5, chan4, chan3, chan2, chan1, chan0};
            observed.auto_mode      = auto_mode;
            observed.frame_complete = frame_complete;
            observed.timed_out      = timed_out;
            observed.tick_count     = tick_count;
            scoreboard.check_result(observed);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d outputs still awaited.",
                scoreboard.pending_outputs.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic word_kind, input logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        kind     = word_kind;
        rx_byte  = data;
        do
            @(posedge clk);
        while (in_stall);
        scoreboard.note_word(word_kind, data);
        words_sent++;
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        in_valid = 1'b0;
        while (scoreboard.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic reg_idx, input logic is_write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = {reg_idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input int unsigned limit, input int unsigned thresh);
        logic [31:0] rdata;
        drain_outputs();
        apb_access(REG_TIMEOUT_LIMIT, 1'b1, ($urandom() << LIMIT_W) | limit, rdata);
        scoreboard.timeout_limit = limit[LIMIT_W-1:0];
        apb_access(REG_AUTO_THRESHOLD, 1'b1, ($urandom() << CHAN_W) | thresh, rdata);
        scoreboard.auto_threshold = thresh[CHAN_W-1:0];
        apb_access(REG_TIMEOUT_LIMIT, 1'b0, 32'd0, rdata);
        if (rdata !== 32'(scoreboard.timeout_limit))
            scoreboard.report_mismatch($sformatf("timeout_limit reads %0d expected %0d",
                rdata, scoreboard.timeout_limit));
        apb_access(REG_AUTO_THRESHOLD, 1'b0, 32'd0, rdata);
        if (rdata !== 32'(scoreboard.auto_threshold))
            scoreboard.report_mismatch($sformatf("auto_threshold reads %0d expected %0d",
                rdata, scoreboard.auto_threshold));
    endtask

    task automatic send_frame();
        logic [7:0]        fb [FRAME_LEN];
        logic [CHAN_W-1:0] value;
        int unsigned       n_bytes;
        int unsigned       extra;
        for (int s = 0; s < NUM_CHANS; s++)
        begin
            value = CHAN_W'($urandom_range(1023));
            if (SLOT_CHAN[s] == GAIN_CHAN && $urandom_range(3) == 0)
                value = scoreboard.auto_threshold + CHAN_W'($urandom_range(1));
            fb[2*s]   = {3'b000, SLOT_CHAN[s], value[9:8]};
            fb[2*s+1] = value[7:0];
            if ($urandom_range(9) == 0)
                fb[2*s] = 8'($urandom_range(255));
        end
        fb[MARKER_INDEX] = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : MARKER_BYTE;
        fb[FRAME_LEN-1]  = 8'($urandom_range(255));
        n_bytes = ($urandom_range(9) == 0) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
        extra   = ($urandom_range(5) == 0) ? $urandom_range(1, 3) : 0;
        send_word(KIND_BYTE, SYNC_FIRST);
        send_word(KIND_BYTE, SYNC_SECOND);
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(9) == 0)
                send_word(KIND_TICK, 8'($urandom_range(255)));
            send_word(KIND_BYTE, fb[i]);
        end
        repeat (extra) send_word(KIND_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        target = words_sent + count;
        while (words_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_frame();
            else if (pick < 78)
                repeat ($urandom_range(1, 30)) send_word(KIND_TICK, 8'($urandom_range(255)));
            else
                repeat ($urandom_range(1, 8))
                    send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_gap_pct = 6;
        stall_pct    = 67;
        foreach (DIRECTED[i])
            send_word(DIRECTED[i][8], DIRECTED[i][7:0]);

        for (int p = 0; p < 6; p++)
        begin
            send_gap_pct = (p < 2) ? 6 : (p < 4) ? 67 : 0;
            stall_pct    = (p < 2) ? 67 : (p < 4) ? 6 : 0;
            if (p > 0)
                set_config(PHASE_LIMIT[p], PHASE_THRESH[p]);
            run_random(PHASE_WORDS);
        end

        drain_outputs();
        repeat (10) @(posedge clk);

        $display("Checked %0d output words for %0d input words; %0d frames decoded.",
            scoreboard.outputs_checked, words_sent, scoreboard.frames_decoded);
        $display("Saw %0d timeout reports across six register settings and three pacing mixes.",
            scoreboard.timeouts_seen);
        if (scoreboard.mismatches == 0 && scoreboard.pending_outputs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
